// ----- rtl/wtc_pkg.sv -----
// Shared constants and types of the window template correlation block.
`timescale 1ns / 1ps
`default_nettype none
package wtc_pkg;

  // Store sizes
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_SIDE    = 16;
  localparam int FRAME_XW    = $clog2(MAX_WIDTH);
  localparam int FRAME_YW    = $clog2(MAX_HEIGHT);
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int TAP_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int TAP_AW      = $clog2(TAP_DEPTH);

  // Datapath widths
  localparam int MUL_AW  = 48;   // multiplier operand (iterated bit by bit)
  localparam int MUL_PW  = 96;   // multiplicand and product
  localparam int SRCH_W  = 128;  // root search compare width
  localparam int CORR_W  = 16;
  localparam int CORR_BW = $clog2(CORR_W);

  typedef enum logic [1:0] {
    FUNC_WR_PIXEL = 2'd0,
    FUNC_WR_TAP   = 2'd1,
    FUNC_QUERY    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_WINDOW_SIDE     = 2'd2,
    REG_MATCH_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL_LP,
    ST_MUL_SC,
    ST_MUL_LQ,
    ST_MUL_SS,
    ST_MUL_LK,
    ST_CHECK,
    ST_MUL_DEN,
    ST_MUL_NSQ,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_CROSS,
    PH_SQUARE,
    PH_TEST
  } phase_e;

endpackage
`default_nettype wire

// ----- rtl/wtc_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/wtc_mul.sv -----
// Shared shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wtc_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wtc_pkg::MUL_AW-1:0] mplier_i,
  input  logic [wtc_pkg::MUL_PW-1:0] mcand_i,
  output logic                      done_o,
  output logic [wtc_pkg::MUL_PW-1:0] prod_o
);

  logic                       run_q;
  logic [wtc_pkg::MUL_AW-1:0] a_q;
  logic [wtc_pkg::MUL_PW-1:0] b_q;
  logic [wtc_pkg::MUL_PW-1:0] acc_q;

  // run ends once the multiplier has no set bits left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (a_q == '0) begin
      run_q <= 1'b0;
    end
  end

  // modular add keeps a signed multiplicand correct
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= mplier_i;
      b_q   <= mcand_i;
      acc_q <= '0;
    end else if (run_q && a_q != '0) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign done_o = run_q && (a_q == '0) && !start_i;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// ----- rtl/wtc_search.sv -----
// Bit-by-bit search for the largest q with q*q*den <= target.
`timescale 1ns / 1ps
`default_nettype none
module wtc_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wtc_pkg::SRCH_W-1:0] den_i,
  input  logic [wtc_pkg::SRCH_W-1:0] target_i,
  output logic                       done_o,
  output logic [wtc_pkg::CORR_W-1:0] corr_o
);

  logic                        run_q;
  logic                        done_q;
  logic [wtc_pkg::CORR_BW-1:0] bit_q;
  wtc_pkg::phase_e             phase_q;
  logic [wtc_pkg::SRCH_W-1:0]  d2_q;   // corr^2 * den
  logic [wtc_pkg::SRCH_W-1:0]  d1_q;   // corr * den
  logic [wtc_pkg::SRCH_W-1:0]  tmp_q;
  logic [wtc_pkg::SRCH_W-1:0]  den_q;
  logic [wtc_pkg::SRCH_W-1:0]  tgt_q;
  logic [wtc_pkg::CORR_W-1:0]  corr_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
      phase_q <= wtc_pkg::PH_CROSS;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        bit_q   <= wtc_pkg::CORR_BW'(wtc_pkg::CORR_W - 1);
        phase_q <= wtc_pkg::PH_CROSS;
      end else if (run_q) begin
        case (phase_q)
          wtc_pkg::PH_CROSS:  phase_q <= wtc_pkg::PH_SQUARE;
          wtc_pkg::PH_SQUARE: phase_q <= wtc_pkg::PH_TEST;
          default: begin
            phase_q <= wtc_pkg::PH_CROSS;
            if (bit_q == '0) begin
              run_q  <= 1'b0;
              done_q <= 1'b1;
            end else begin
              bit_q <= bit_q - 1'b1;
            end
          end
        endcase
      end
    end
  end

  // (corr + 2^k)^2 den = d2 + d1*2^(k+1) + den*2^(2k)
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d2_q   <= '0;
      d1_q   <= '0;
      corr_q <= '0;
      den_q  <= den_i;
      tgt_q  <= target_i;
    end else if (run_q) begin
      case (phase_q)
        wtc_pkg::PH_CROSS:  tmp_q <= d2_q + (d1_q << ({1'b0, bit_q} + 1'b1));
        wtc_pkg::PH_SQUARE: tmp_q <= tmp_q + (den_q << {bit_q, 1'b0});
        default: begin
          if (tmp_q <= tgt_q) begin
            d2_q          <= tmp_q;
            d1_q          <= d1_q + (den_q << bit_q);
            corr_q[bit_q] <= 1'b1;
          end
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign corr_o = corr_q;

endmodule
`default_nettype wire

// ----- rtl/window_template_correlation_unit.sv -----
// Top level: frame and template stores, window scan, sequencer and result word.
//
// Pixel and template writes are accepted while the unit is idle. A query scans
// the window over side*side elements (one frame RAM and one template RAM read
// per cycle, then the registered reads drain; a zero side skips the scan), then
// one shared shift-add multiplier forms five products and, unless the check
// step ends the query, two more, each working through its multiplier operand
// bit by bit, then the root search settles one result bit at a time in cross,
// square and test phases. The input stalls meanwhile. A finished result word
// waits in the output register while further words are accepted. No clearing
// pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module window_template_correlation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         x_coord_i,
  input  logic [7:0]         y_coord_i,
  input  logic [7:0]         pixel_value_i,
  input  logic [7:0]         tap_index_i,
  input  logic signed [15:0] tap_value_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        correlation_o,
  output logic               above_threshold_o,
  output logic               degenerate_o
);

  // configuration registers
  logic [8:0]  frame_width_q, frame_height_q;
  logic [4:0]  window_side_q;
  logic [15:0] match_threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= 9'd256;
      frame_height_q    <= 9'd256;
      window_side_q     <= 5'd8;
      match_threshold_q <= 16'd45875;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wtc_pkg::REG_FRAME_WIDTH:     frame_width_q     <= cfg_data_i[8:0];
        wtc_pkg::REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data_i[8:0];
        wtc_pkg::REG_WINDOW_SIDE:     window_side_q     <= cfg_data_i[4:0];
        wtc_pkg::REG_MATCH_THRESHOLD: match_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [9:0] w_eff, h_eff;
  logic [4:0] side_eff;
  assign w_eff = (32'(frame_width_q) > wtc_pkg::MAX_WIDTH) ? 10'(wtc_pkg::MAX_WIDTH)
                                                          : {1'b0, frame_width_q};
  assign h_eff = (32'(frame_height_q) > wtc_pkg::MAX_HEIGHT) ? 10'(wtc_pkg::MAX_HEIGHT)
                                                            : {1'b0, frame_height_q};
  assign side_eff = (32'(window_side_q) > wtc_pkg::MAX_SIDE) ? 5'(wtc_pkg::MAX_SIDE)
                                                            : window_side_q;

  // state and handshake
  wtc_pkg::state_e state_q, state_d;
  logic            started_q, started_d;
  logic            in_acc, is_query;

  assign in_stall_o = (state_q != wtc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_query   = (func_i == wtc_pkg::FUNC_QUERY);

  // window scan registers
  logic [7:0]                 x_q, y_q;
  logic [4:0]                 side_q;
  logic [8:0]                 len_q;
  logic [4:0]                 row_q, col_q;
  logic [wtc_pkg::TAP_AW-1:0] idx_q;
  logic                       pipe_v_q, in_frame_q;
  logic                       scan_last;
  logic signed [10:0]         px, py;
  logic                       in_frame;

  assign px = $signed({3'b0, x_q}) - $signed({7'b0, side_q[4:1]}) + $signed({6'b0, col_q});
  assign py = $signed({3'b0, y_q}) - $signed({7'b0, side_q[4:1]}) + $signed({6'b0, row_q});
  assign in_frame = !px[10] && !py[10] && (px[9:0] < w_eff) && (py[9:0] < h_eff);
  assign scan_last = (row_q == side_q - 5'd1) && (col_q == side_q - 5'd1);

  // stores
  logic                                       frame_we, tap_we;
  logic [wtc_pkg::FRAME_XW+wtc_pkg::FRAME_YW-1:0] frame_addr;
  logic [wtc_pkg::TAP_AW-1:0]                 tap_addr;
  logic [7:0]                                 frame_rdata;
  logic [15:0]                                tap_rdata;

  assign frame_we = in_acc && (func_i == wtc_pkg::FUNC_WR_PIXEL)
                 && (32'(x_coord_i) < wtc_pkg::MAX_WIDTH)
                 && (32'(y_coord_i) < wtc_pkg::MAX_HEIGHT);
  assign tap_we   = in_acc && (func_i == wtc_pkg::FUNC_WR_TAP)
                 && (32'(tap_index_i) < wtc_pkg::TAP_DEPTH);
  assign frame_addr = (state_q == wtc_pkg::ST_IDLE)
      ? {y_coord_i[wtc_pkg::FRAME_YW-1:0], x_coord_i[wtc_pkg::FRAME_XW-1:0]}
      : {py[wtc_pkg::FRAME_YW-1:0], px[wtc_pkg::FRAME_XW-1:0]};
  assign tap_addr = (state_q == wtc_pkg::ST_IDLE) ? tap_index_i[wtc_pkg::TAP_AW-1:0] : idx_q;

  wtc_ram #(.WIDTH(8), .DEPTH(wtc_pkg::FRAME_DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .addr_i  (frame_addr),
    .wdata_i (pixel_value_i),
    .rdata_o (frame_rdata)
  );

  wtc_ram #(.WIDTH(16), .DEPTH(wtc_pkg::TAP_DEPTH)) u_tmpl (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .addr_i  (tap_addr),
    .wdata_i (tap_value_i),
    .rdata_o (tap_rdata)
  );

  // accumulate one window element per cycle
  logic [7:0]         pv;
  logic signed [15:0] cv;
  logic signed [24:0] pc_prod;
  logic signed [31:0] cc_prod;
  logic [15:0]        pp_prod;
  logic [16:0]        s_q;
  logic signed [33:0] p_q;
  logic signed [24:0] c_q;
  logic [24:0]        q_q;
  logic [38:0]        k_q;

  assign pv      = in_frame_q ? frame_rdata : 8'd0;
  assign cv      = $signed(tap_rdata);
  assign pc_prod = $signed({1'b0, pv}) * cv;
  assign cc_prod = cv * cv;
  assign pp_prod = pv * pv;

  // shared multiplier and root search
  logic                       mul_start, mul_done;
  logic [wtc_pkg::MUL_AW-1:0] mul_a;
  logic [wtc_pkg::MUL_PW-1:0] mul_b, mul_prod;
  logic                       srch_start, srch_done;
  logic [wtc_pkg::CORR_W-1:0] srch_corr;

  logic signed [43:0] lp_q, num_q;
  logic [35:0]        lq_q, a_q;
  logic [46:0]        b_q;
  logic [wtc_pkg::MUL_PW-1:0] den_q, nsq_q;
  logic signed [36:0] a_diff;
  logic [15:0]        res_corr_q;
  logic               res_degen_q;

  assign a_diff = $signed({1'b0, lq_q}) - $signed({1'b0, mul_prod[35:0]});

  wtc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mplier_i (mul_a),
    .mcand_i  (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  wtc_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (srch_start),
    .den_i    (wtc_pkg::SRCH_W'(den_q)),
    .target_i ({nsq_q, 32'd0}),
    .done_o   (srch_done),
    .corr_o   (srch_corr)
  );

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      wtc_pkg::ST_MUL_LP:  begin mul_a = wtc_pkg::MUL_AW'(len_q); mul_b = wtc_pkg::MUL_PW'(p_q); end
      wtc_pkg::ST_MUL_SC:  begin mul_a = wtc_pkg::MUL_AW'(s_q);   mul_b = wtc_pkg::MUL_PW'(c_q); end
      wtc_pkg::ST_MUL_LQ:  begin mul_a = wtc_pkg::MUL_AW'(len_q); mul_b = wtc_pkg::MUL_PW'(q_q); end
      wtc_pkg::ST_MUL_SS:  begin mul_a = wtc_pkg::MUL_AW'(s_q);   mul_b = wtc_pkg::MUL_PW'(s_q); end
      wtc_pkg::ST_MUL_LK:  begin mul_a = wtc_pkg::MUL_AW'(len_q); mul_b = wtc_pkg::MUL_PW'(k_q); end
      wtc_pkg::ST_MUL_DEN: begin mul_a = wtc_pkg::MUL_AW'(a_q);   mul_b = wtc_pkg::MUL_PW'(b_q); end
      wtc_pkg::ST_MUL_NSQ: begin
        mul_a = wtc_pkg::MUL_AW'(num_q[42:0]);
        mul_b = wtc_pkg::MUL_PW'(num_q[42:0]);
      end
      default: ;
    endcase
  end

  // sequencer
  logic is_mul_state;
  logic load_out;

  assign is_mul_state = (state_q == wtc_pkg::ST_MUL_LP)  || (state_q == wtc_pkg::ST_MUL_SC)
                     || (state_q == wtc_pkg::ST_MUL_LQ)  || (state_q == wtc_pkg::ST_MUL_SS)
                     || (state_q == wtc_pkg::ST_MUL_LK)  || (state_q == wtc_pkg::ST_MUL_DEN)
                     || (state_q == wtc_pkg::ST_MUL_NSQ);

  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    mul_start  = 1'b0;
    srch_start = 1'b0;
    load_out   = 1'b0;
    if (is_mul_state) begin
      if (!started_q) begin
        mul_start = 1'b1;
        started_d = 1'b1;
      end else if (mul_done) begin
        started_d = 1'b0;
      end
    end
    case (state_q)
      wtc_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (side_eff == 5'd0) ? wtc_pkg::ST_MUL_LP : wtc_pkg::ST_SCAN;
        end
      end
      wtc_pkg::ST_SCAN:  if (scan_last) state_d = wtc_pkg::ST_DRAIN;
      wtc_pkg::ST_DRAIN: if (!pipe_v_q) state_d = wtc_pkg::ST_MUL_LP;
      wtc_pkg::ST_MUL_LP: if (started_q && mul_done) state_d = wtc_pkg::ST_MUL_SC;
      wtc_pkg::ST_MUL_SC: if (started_q && mul_done) state_d = wtc_pkg::ST_MUL_LQ;
      wtc_pkg::ST_MUL_LQ: if (started_q && mul_done) state_d = wtc_pkg::ST_MUL_SS;
      wtc_pkg::ST_MUL_SS: if (started_q && mul_done) state_d = wtc_pkg::ST_MUL_LK;
      wtc_pkg::ST_MUL_LK: if (started_q && mul_done) state_d = wtc_pkg::ST_CHECK;
      wtc_pkg::ST_CHECK: begin
        if (a_q == '0 || b_q == '0 || num_q[43] || num_q == '0) begin
          state_d = wtc_pkg::ST_DONE;
        end else begin
          state_d = wtc_pkg::ST_MUL_DEN;
        end
      end
      wtc_pkg::ST_MUL_DEN: if (started_q && mul_done) state_d = wtc_pkg::ST_MUL_NSQ;
      wtc_pkg::ST_MUL_NSQ: if (started_q && mul_done) state_d = wtc_pkg::ST_SEARCH;
      wtc_pkg::ST_SEARCH: begin
        if (!started_q) begin
          srch_start = 1'b1;
          started_d  = 1'b1;
        end else if (srch_done) begin
          started_d = 1'b0;
          state_d   = wtc_pkg::ST_DONE;
        end
      end
      wtc_pkg::ST_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = wtc_pkg::ST_IDLE;
        end
      end
      default: state_d = wtc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wtc_pkg::ST_IDLE;
      started_q <= 1'b0;
      pipe_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      pipe_v_q  <= (state_q == wtc_pkg::ST_SCAN);
    end
  end

  // scan counters and accumulators
  always_ff @(posedge clk_i) begin
    in_frame_q <= in_frame;
    if (in_acc && is_query) begin
      x_q    <= x_coord_i;
      y_q    <= y_coord_i;
      side_q <= side_eff;
      len_q  <= {4'b0, side_eff} * {4'b0, side_eff};
      row_q  <= '0;
      col_q  <= '0;
      idx_q  <= '0;
      s_q    <= '0;
      p_q    <= '0;
      c_q    <= '0;
      q_q    <= '0;
      k_q    <= '0;
    end else begin
      if (state_q == wtc_pkg::ST_SCAN) begin
        idx_q <= idx_q + 1'b1;
        if (col_q == side_q - 5'd1) begin
          col_q <= '0;
          row_q <= row_q + 5'd1;
        end else begin
          col_q <= col_q + 5'd1;
        end
      end
      if (pipe_v_q) begin
        s_q <= s_q + 17'(pv);
        p_q <= p_q + 34'(pc_prod);
        c_q <= c_q + cv;
        q_q <= q_q + 25'(pp_prod);
        k_q <= k_q + 39'(cc_prod[30:0]);
      end
    end
  end

  // product captures and result
  always_ff @(posedge clk_i) begin
    if (started_q && mul_done) begin
      case (state_q)
        wtc_pkg::ST_MUL_LP:  lp_q  <= $signed(mul_prod[43:0]);
        wtc_pkg::ST_MUL_SC:  num_q <= lp_q - $signed(mul_prod[43:0]);
        wtc_pkg::ST_MUL_LQ:  lq_q  <= mul_prod[35:0];
        wtc_pkg::ST_MUL_SS:  a_q   <= a_diff[36] ? 36'd0 : a_diff[35:0];
        wtc_pkg::ST_MUL_LK:  b_q   <= mul_prod[46:0];
        wtc_pkg::ST_MUL_DEN: den_q <= mul_prod;
        wtc_pkg::ST_MUL_NSQ: nsq_q <= mul_prod;
        default: ;
      endcase
    end
    if (state_q == wtc_pkg::ST_CHECK) begin
      res_corr_q  <= '0;
      res_degen_q <= (a_q == '0) || (b_q == '0);
    end else if (state_q == wtc_pkg::ST_SEARCH && started_q && srch_done) begin
      res_corr_q <= srch_corr;
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      correlation_o     <= res_corr_q;
      above_threshold_o <= (res_corr_q >= match_threshold_q);
      degenerate_o      <= res_degen_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
